@@ rtl/core/tsrm_pkg.sv @@
// Shared types and constants of the tagged slot ring manager.
`timescale 1ns / 1ps
package tsrm_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam logic [2:0] CMD_STORE    = 3'd0;
    localparam logic [2:0] CMD_FIND     = 3'd1;
    localparam logic [2:0] CMD_FIND_DEL = 3'd2;
    localparam logic [2:0] CMD_DEL_SLOT = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_SLOT_BYTES   = 2'd1;

    localparam logic [31:0] BASE_ADDRESS_RESET = 32'd0;
    localparam logic [15:0] SLOT_BYTES_RESET   = 16'd512;

    // Contents of one slot cell.
    typedef struct packed {
        logic       valid;
        logic [7:0] ptype;
    } t_cell_data;

    // Shift and clear control shared by every cell of the ring.
    typedef struct packed {
        logic shift;
        logic fwd;
        logic clear;
    } t_ring_ctl;

    // Local write into one cell.
    typedef struct packed {
        logic       en;
        t_cell_data data;
    } t_cell_wr;

endpackage

@@ rtl/core/tagged_slot_ring_manager_unit.sv @@
// Top level of the tagged slot ring manager: sequencer over a rotating ring of slot cells.
//
//   channel   | signals                                              | handshake
//   ----------+------------------------------------------------------+---------------------
//   command   | i_cmd i_pkt_type i_type_masked i_skip_count i_slot_index | i_start & !o_busy
//   config    | i_cfg_index i_cfg_data                               | i_cfg_valid & o_cfg_ready
//   result    | o_ok o_slot o_address o_count                        | o_valid, one cycle
//
// The slot cells rotate one place a cycle while the sequencer shifts them; cell 0 is
// the window the sequencer reads. Clear, an unused code and a find on an empty ring go
// straight to the multiply state; other commands first seek, up to SLOTS/2 rotations,
// and may add a find walk of up to SLOTS cells and a head advance of up to SLOTS cells.
// Then come the multiply and output states. A store seeks the tail, first evicting the
// head when full. Reset is synchronous and empties the ring. The result word sits on
// the ports in the first cycle that o_busy is low and cannot be stalled.
module tagged_slot_ring_manager_unit #(
    parameter int SLOTS = tsrm_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_pkt_type,
    input  logic        i_type_masked,
    input  logic [7:0]  i_skip_count,
    input  logic [5:0]  i_slot_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_ok,
    output logic [5:0]  o_slot,
    output logic [31:0] o_address,
    output logic [6:0]  o_count
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL = CW'(SLOTS);
    localparam logic [PW:0]   HALF = (PW + 1)'(SLOTS / 2);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SEEK   = 10'b0000000010,
        S_WALK   = 10'b0000000100,
        S_CHECK  = 10'b0000001000,
        S_STORE  = 10'b0000010000,
        S_REMOVE = 10'b0000100000,
        S_HADV   = 10'b0001000000,
        S_MUL    = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_EVICT  = 10'b1000000000
    } t_state;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [PW-1:0] prev_slot(input logic [PW-1:0] s);
        return (s == '0) ? LAST : s - 1'b1;
    endfunction

    t_state r_state, n_state;
    logic [31:0] r_base, r_bytes32;
    logic [15:0] r_bytes;
    logic [2:0]  r_cmd, n_cmd;
    logic [7:0]  r_ptype, n_ptype;
    logic        r_masked, n_masked;
    logic [7:0]  r_skip, n_skip;
    logic [PW-1:0] r_head, n_head, r_tail, n_tail, r_rot, n_rot;
    logic [PW-1:0] r_target, n_target, r_hit, n_hit;
    logic [CW-1:0] r_count, n_count, r_n, n_n, r_i, n_i, r_seen, n_seen;
    logic [CW-1:0] r_guard, n_guard;
    logic [7:0]  r_matched, n_matched;
    logic        r_ok, n_ok;
    logic [31:0] r_prod;
    logic        r_valid;
    logic        r_o_ok;
    logic [5:0]  r_o_slot;
    logic [31:0] r_o_address;
    logic [6:0]  r_o_count;

    tsrm_pkg::t_ring_ctl  ring_ctl;
    tsrm_pkg::t_cell_wr   wr0;
    tsrm_pkg::t_cell_data cell_q [SLOTS];
    tsrm_pkg::t_cell_data win;

    logic [PW:0]   seek_dist;
    logic [CW-1:0] walk_len, seen_inc, i_inc;
    logic          match;

    assign win = cell_q[0];

    // Build the ring of cells; only cell 0 takes local writes
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        tsrm_pkg::t_cell_wr wr_k;
        assign wr_k = (k == 0) ? wr0 : '0;
        tsrm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ring_ctl),
            .i_wr   (wr_k),
            .i_prev (cell_q[(k + SLOTS - 1) % SLOTS]),
            .i_next (cell_q[(k + 1) % SLOTS]),
            .o_data (cell_q[k])
        );
    end

    // Take configuration words
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= tsrm_pkg::BASE_ADDRESS_RESET;
            r_bytes <= tsrm_pkg::SLOT_BYTES_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tsrm_pkg::REG_BASE_ADDRESS) begin
                r_base <= i_cfg_data;
            end else if (i_cfg_index == tsrm_pkg::REG_SLOT_BYTES) begin
                r_bytes <= i_cfg_data[15:0];
            end
        end
    end
    assign r_bytes32 = {16'd0, r_bytes};

    // Shared helpers for the sequencer
    always_comb begin
        if (r_target >= r_rot) begin
            seek_dist = {1'b0, r_target} - {1'b0, r_rot};
        end else begin
            seek_dist = (PW + 1)'(SLOTS) - {1'b0, r_rot} + {1'b0, r_target};
        end
        if (r_tail >= r_head) begin
            walk_len = CW'(r_tail - r_head);
        end else begin
            walk_len = FULL - CW'(r_head) + CW'(r_tail);
        end
        if (walk_len == '0) begin
            walk_len = FULL;
        end
        match    = !r_masked || (win.ptype == r_ptype);
        seen_inc = r_seen + (win.valid ? CW'(1) : CW'(0));
        i_inc    = r_i + 1'b1;
    end

    // Sequence one command over the ring
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ptype   = r_ptype;
        n_masked  = r_masked;
        n_skip    = r_skip;
        n_head    = r_head;
        n_tail    = r_tail;
        n_rot     = r_rot;
        n_target  = r_target;
        n_hit     = r_hit;
        n_count   = r_count;
        n_n       = r_n;
        n_i       = r_i;
        n_seen    = r_seen;
        n_guard   = r_guard;
        n_matched = r_matched;
        n_ok      = r_ok;
        ring_ctl  = '0;
        wr0       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_cmd;
                    n_ptype   = i_pkt_type;
                    n_masked  = i_type_masked;
                    n_skip    = i_skip_count;
                    n_ok      = 1'b0;
                    n_hit     = '0;
                    n_i       = '0;
                    n_seen    = '0;
                    n_matched = '0;
                    n_state   = S_MUL;
                    if (i_cmd == tsrm_pkg::CMD_STORE) begin
                        // A full ring first visits the head to evict it
                        n_target = (r_count >= FULL) ? r_head : r_tail;
                        n_state  = S_SEEK;
                    end else if (i_cmd == tsrm_pkg::CMD_FIND ||
                                 i_cmd == tsrm_pkg::CMD_FIND_DEL) begin
                        if (r_count != '0) begin
                            n_target = prev_slot(r_tail);
                            n_n      = walk_len;
                            n_state  = S_SEEK;
                        end
                    end else if (i_cmd == tsrm_pkg::CMD_DEL_SLOT) begin
                        if (32'(i_slot_index) < 32'(SLOTS)) begin
                            n_target = PW'(i_slot_index);
                            n_state  = S_SEEK;
                        end
                    end else if (i_cmd == tsrm_pkg::CMD_CLEAR) begin
                        ring_ctl.clear = 1'b1;
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                end
            end
            S_SEEK: begin
                // Rotate the shorter way until the target sits in the window
                if (seek_dist == '0) begin
                    if (r_cmd == tsrm_pkg::CMD_STORE) begin
                        n_state = (r_count >= FULL) ? S_EVICT : S_STORE;
                    end else if (r_cmd == tsrm_pkg::CMD_DEL_SLOT) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_WALK;
                    end
                end else begin
                    ring_ctl.shift = 1'b1;
                    ring_ctl.fwd   = (seek_dist <= HALF);
                    n_rot = ring_ctl.fwd ? next_slot(r_rot) : prev_slot(r_rot);
                end
            end
            S_EVICT: begin
                // Drop the oldest slot, then head for the tail
                wr0.en   = 1'b1;
                n_head   = next_slot(r_head);
                n_count  = r_count - 1'b1;
                n_target = r_tail;
                n_state  = S_SEEK;
            end
            S_WALK: begin
                // Step from newest to oldest, counting valid and matching slots
                n_seen = seen_inc;
                if (win.valid && match && r_matched >= r_skip) begin
                    n_hit = r_rot;
                    n_ok  = 1'b1;
                    n_state = (r_cmd == tsrm_pkg::CMD_FIND_DEL) ? S_REMOVE : S_MUL;
                end else begin
                    if (win.valid && match) begin
                        n_matched = r_matched + 1'b1;
                    end
                    n_i = i_inc;
                    if (i_inc == r_n) begin
                        if (seen_inc != r_count) begin
                            n_count = seen_inc;
                        end
                        n_state = S_MUL;
                    end else begin
                        ring_ctl.shift = 1'b1;
                        n_rot = prev_slot(r_rot);
                    end
                end
            end
            S_CHECK: begin
                if (win.valid) begin
                    n_hit   = r_rot;
                    n_ok    = 1'b1;
                    n_state = S_REMOVE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_STORE: begin
                wr0.en         = 1'b1;
                wr0.data.valid = 1'b1;
                wr0.data.ptype = r_ptype;
                n_count = r_count + 1'b1;
                n_tail  = next_slot(r_tail);
                n_hit   = r_rot;
                n_ok    = 1'b1;
                n_state = S_MUL;
            end
            S_REMOVE: begin
                // Drop the slot, pull the tail back onto it if newest
                wr0.en = 1'b1;
                if (r_rot == prev_slot(r_tail)) begin
                    n_tail = r_rot;
                end
                n_guard = '0;
                if (r_rot == r_head) begin
                    n_state = S_HADV;
                end else begin
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_MUL;
                end
            end
            S_HADV: begin
                // Advance the head past dead slots, stopping at the tail
                if (r_count > CW'(1) && !win.valid && r_guard < FULL &&
                    next_slot(r_head) != r_tail) begin
                    n_head  = next_slot(r_head);
                    n_guard = r_guard + 1'b1;
                    ring_ctl.shift = 1'b1;
                    ring_ctl.fwd   = 1'b1;
                    n_rot = next_slot(r_rot);
                end else begin
                    if (r_count > CW'(1) && !win.valid && r_guard < FULL) begin
                        n_head = next_slot(r_head);
                    end
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_rot   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_rot   <= n_rot;
            r_count <= n_count;
        end
    end

    // Hold command operands and walk counters
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_ptype   <= n_ptype;
        r_masked  <= n_masked;
        r_skip    <= n_skip;
        r_target  <= n_target;
        r_hit     <= n_hit;
        r_n       <= n_n;
        r_i       <= n_i;
        r_seen    <= n_seen;
        r_guard   <= n_guard;
        r_matched <= n_matched;
        r_ok      <= n_ok;
        if (r_state == S_MUL) begin
            r_prod <= 32'(32'(r_hit) * r_bytes32);
        end
    end

    // Drive the result word for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EMIT);
        end
        if (r_state == S_EMIT) begin
            r_o_ok      <= r_ok;
            r_o_slot    <= r_ok ? 6'(r_hit) : 6'd0;
            r_o_address <= (r_ok && r_cmd != tsrm_pkg::CMD_CLEAR) ? r_base + r_prod : 32'd0;
            r_o_count   <= 7'(r_count);
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_ok      = r_o_ok;
    assign o_slot    = r_o_slot;
    assign o_address = r_o_address;
    assign o_count   = r_o_count;

endmodule

@@ rtl/core/tsrm_cell.sv @@
// One slot cell of the rotating metadata ring.
`timescale 1ns / 1ps
module tsrm_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsrm_pkg::t_ring_ctl  i_ctl,
    input  tsrm_pkg::t_cell_wr   i_wr,
    input  tsrm_pkg::t_cell_data i_prev,
    input  tsrm_pkg::t_cell_data i_next,
    output tsrm_pkg::t_cell_data o_data
);

    tsrm_pkg::t_cell_data r_data;

    // Clear, take a local write, or take a neighbor's word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_data <= '0;
        end else if (i_wr.en) begin
            r_data <= i_wr.data;
        end else if (i_ctl.shift) begin
            r_data <= i_ctl.fwd ? i_next : i_prev;
        end
    end

    assign o_data = r_data;

endmodule
